>>> rtl/core/bfm_pkg.sv
// Shared types and constants for the Brainfuck machine.
// Holds the function, mode, opcode, error and sequencer codes, the word layouts
// and the source character decoder. No dependencies.
package bfm_pkg;

   // Function selector carried with each request word
   typedef enum logic [1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_EOS     = 2'd1,
      FUNC_EXEC    = 2'd2,
      FUNC_RESTART = 2'd3
   } func_type;

   // Machine mode
   typedef enum logic [1:0] {
      MODE_LOADING = 2'd0,
      MODE_READY   = 2'd1,
      MODE_HALTED  = 2'd2,
      MODE_ERROR   = 2'd3
   } mode_type;

   // Instruction opcodes as stored in the program memory
   typedef enum logic [3:0] {
      OPC_END   = 4'd0,
      OPC_RIGHT = 4'd1,
      OPC_LEFT  = 4'd2,
      OPC_INC   = 4'd3,
      OPC_DEC   = 4'd4,
      OPC_PUT   = 4'd5,
      OPC_GET   = 4'd6,
      OPC_OPEN  = 4'd7,
      OPC_CLOSE = 4'd8
   } opc_type;

   localparam int unsigned OPC_WIDTH = 4;

   // Error codes reported in every response word
   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_DEEP       = 3'd1,
      ERR_UNMATCHED  = 3'd2,
      ERR_TOO_LARGE  = 3'd3,
      ERR_UNCLOSED   = 3'd4,
      ERR_NOT_LOADED = 3'd5
   } err_type;

   // Control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_CLOSE = 2'd1,
      ST_PATCH = 2'd2,
      ST_EXEC  = 2'd3
   } state_type;

   // Command characters
   localparam logic [7:0] CH_RIGHT = 8'h3E;   // '>'
   localparam logic [7:0] CH_LEFT  = 8'h3C;   // '<'
   localparam logic [7:0] CH_INC   = 8'h2B;   // '+'
   localparam logic [7:0] CH_DEC   = 8'h2D;   // '-'
   localparam logic [7:0] CH_PUT   = 8'h2E;   // '.'
   localparam logic [7:0] CH_GET   = 8'h2C;   // ','
   localparam logic [7:0] CH_OPEN  = 8'h5B;   // '['
   localparam logic [7:0] CH_CLOSE = 8'h5D;   // ']'

   // One request word after capture
   typedef struct packed {
      func_type   func;
      logic [7:0] src_char;
      logic [7:0] in_byte;
      logic       in_eof;
   } item_type;

   // One response word
   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       input_taken;
      logic       halted;
      logic       ready_to_run;
      err_type    error_code;
   } result_type;

   // Controls from the sequencer to the cell store
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } cell_cmd_type;

   // Non-command characters map to OPC_END, which no command character produces
   function automatic opc_type decode_char(input logic [7:0] ch);
      opc_type opc;
      case (ch)
         CH_RIGHT: opc = OPC_RIGHT;
         CH_LEFT:  opc = OPC_LEFT;
         CH_INC:   opc = OPC_INC;
         CH_DEC:   opc = OPC_DEC;
         CH_PUT:   opc = OPC_PUT;
         CH_GET:   opc = OPC_GET;
         CH_OPEN:  opc = OPC_OPEN;
         CH_CLOSE: opc = OPC_CLOSE;
         default:  opc = OPC_END;
      endcase
      return opc;
   endfunction

endpackage

>>> rtl/core/brainfuck_machine.sv
// Brainfuck machine top level. Execute words read program and cell memory, then execute
// and write back; a ']' pops the stack, writes its close entry, then patches its open.
// One request word is buffered while the sequencer works, and one response word is
// held in the output register, so both sides overlap. Reset is synchronous; after
// reset and after a restart from ready or halted mode a sweep clears the cell store,
// during which no request word is started.
module brainfuck_machine
   import bfm_pkg::*;
#(
   parameter int unsigned PROG_DEPTH  = 4096,
   parameter int unsigned STACK_DEPTH = 512,
   parameter int unsigned DATA_DEPTH  = 128,
   parameter int unsigned CELL_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // src_char[7:0], in_byte[15:8], in_eof[16], zero pad
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // out_valid[0], out_byte[8:1], input_taken[9],
                                    // halted[10], ready_to_run[11], error_code[14:12]
);

   localparam int unsigned DA = $clog2(DATA_DEPTH);

   logic                  buf_valid_ff, buf_valid_in;
   item_type              buf_item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff;
   logic                  req_acc, item_take, out_free, res_valid;
   result_type            res;
   cell_cmd_type          cell_cmd;
   logic [DA-1:0]         cell_addr;
   logic [CELL_WIDTH-1:0] cell_wr_data, cell_rd_data;
   logic                  cell_busy;

   // Input word buffer
   assign req_tready   = !buf_valid_ff || item_take;
   assign req_acc      = req_tvalid && req_tready;
   assign buf_valid_in = req_acc || (buf_valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         buf_item_ff.func     <= func_type'(req_tuser);
         buf_item_ff.src_char <= req_tdata[7:0];
         buf_item_ff.in_byte  <= req_tdata[15:8];
         buf_item_ff.in_eof   <= req_tdata[16];
      end
   end

   // Output word register
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.error_code, rsp_ff.ready_to_run, rsp_ff.halted,
                        rsp_ff.input_taken, rsp_ff.out_byte, rsp_ff.out_valid};

   bfm_ctrl #(
      .PROG_DEPTH  (PROG_DEPTH),
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_DEPTH  (DATA_DEPTH),
      .CELL_WIDTH  (CELL_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (buf_valid_ff),
      .item         (buf_item_ff),
      .item_take    (item_take),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res          (res),
      .cell_cmd     (cell_cmd),
      .cell_addr    (cell_addr),
      .cell_wr_data (cell_wr_data),
      .cell_rd_data (cell_rd_data),
      .cell_busy    (cell_busy)
   );

   bfm_cells #(
      .DATA_DEPTH (DATA_DEPTH),
      .CELL_WIDTH (CELL_WIDTH)
   ) u_cells (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cell_cmd),
      .addr    (cell_addr),
      .wr_data (cell_wr_data),
      .rd_data (cell_rd_data),
      .busy    (cell_busy)
   );

endmodule

>>> rtl/core/bfm_cells.sv
// Data cell store of the Brainfuck machine with its clearing sweep.
// Synchronous memory, separate write address during the sweep, registered read data. Uses bfm_pkg.
module bfm_cells
   import bfm_pkg::*;
#(
   parameter int unsigned DATA_DEPTH = 128,
   parameter int unsigned CELL_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cell_cmd_type                  cmd,
   input  logic [$clog2(DATA_DEPTH)-1:0] addr,
   input  logic [CELL_WIDTH-1:0]         wr_data,
   output logic [CELL_WIDTH-1:0]         rd_data,
   output logic                          busy
);

   localparam int unsigned DA = $clog2(DATA_DEPTH);

   logic [CELL_WIDTH-1:0] cell_mem [DATA_DEPTH];
   logic [CELL_WIDTH-1:0] rd_ff;
   logic                  clr_busy_ff, clr_busy_in;
   logic [DA-1:0]         clr_addr_ff, clr_addr_in;
   logic                  mem_we;
   logic [DA-1:0]         mem_waddr;
   logic [CELL_WIDTH-1:0] mem_wdata;

   // Sweep one cell per cycle after reset or a clear request
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (cmd.clear) begin
         clr_busy_in = 1'b1;
         clr_addr_in = '0;
      end else if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == DA'(DATA_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Write port is shared by the sweep and the sequencer
   assign mem_we    = clr_busy_ff || cmd.wr_en;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : addr;
   assign mem_wdata = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rd_ff <= cell_mem[addr];
      end
   end

   assign rd_data = rd_ff;
   assign busy    = clr_busy_ff;

endmodule

>>> rtl/core/bfm_ctrl.sv
// Sequencer of the Brainfuck machine: loader, bracket matcher and executor.
// Owns the program memory and the bracket stack; drives bfm_cells. Uses bfm_pkg.
module bfm_ctrl
   import bfm_pkg::*;
#(
   parameter int unsigned PROG_DEPTH  = 4096,
   parameter int unsigned STACK_DEPTH = 512,
   parameter int unsigned DATA_DEPTH  = 128,
   parameter int unsigned CELL_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  item_type                      item,
   output logic                          item_take,
   input  logic                          out_free,
   output logic                          res_valid,
   output result_type                    res,
   output cell_cmd_type                  cell_cmd,
   output logic [$clog2(DATA_DEPTH)-1:0] cell_addr,
   output logic [CELL_WIDTH-1:0]         cell_wr_data,
   input  logic [CELL_WIDTH-1:0]         cell_rd_data,
   input  logic                          cell_busy
);

   localparam int unsigned PA  = $clog2(PROG_DEPTH);
   localparam int unsigned SA  = $clog2(STACK_DEPTH);
   localparam int unsigned SDW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned DA  = $clog2(DATA_DEPTH);
   localparam int unsigned IW  = OPC_WIDTH + PA;

   // Program counter style increment, wrapping at the store size
   function automatic logic [PA-1:0] pc_inc(input logic [PA-1:0] v);
      return (v == PA'(PROG_DEPTH - 1)) ? '0 : v + 1'b1;
   endfunction

   // Memories
   logic [IW-1:0] instr_mem [PROG_DEPTH];
   logic [PA-1:0] stack_mem [STACK_DEPTH];
   logic [IW-1:0] instr_rd_ff;
   logic [PA-1:0] stack_rd_ff;

   // Architectural and sequencer state
   state_type      state_ff, state_in;
   mode_type       mode_ff, mode_in;
   err_type        err_ff, err_in;
   logic [SDW-1:0] depth_ff, depth_in;
   logic [PA-1:0]  lc_ff, lc_in;
   logic [PA-1:0]  pc_ff, pc_in;
   logic [DA-1:0]  dp_ff, dp_in;
   logic [PA-1:0]  mate_ff, mate_in;
   logic [7:0]     byte_ff, byte_in;
   logic           eof_ff, eof_in;

   // Memory controls
   logic           instr_we, instr_re;
   logic [PA-1:0]  instr_waddr;
   logic [IW-1:0]  instr_wdata;
   logic           stack_we, stack_re;
   logic [SA-1:0]  stack_waddr, stack_raddr;

   // Decode helpers
   opc_type        ch_opc, ex_opc;
   logic [PA-1:0]  ex_partner;
   logic [SDW-1:0] depth_dec;
   logic           is_cmd, lc_full, stack_full, stack_empty;
   logic           start_close, start_exec, cell_zero;
   logic           not_loaded, put_valid, get_taken;
   logic [7:0]     put_byte;

   assign ch_opc      = decode_char(item.src_char);
   assign is_cmd      = (ch_opc != OPC_END);
   assign lc_full     = (lc_ff == PA'(PROG_DEPTH - 1));
   assign stack_full  = (depth_ff == SDW'(STACK_DEPTH));
   assign stack_empty = (depth_ff == '0);
   assign depth_dec   = depth_ff - 1'b1;
   assign ex_opc      = opc_type'(instr_rd_ff[IW-1:PA]);
   assign ex_partner  = instr_rd_ff[PA-1:0];
   assign cell_zero   = (cell_rd_data == '0);
   assign cell_addr   = dp_ff;

   // Multi-cycle operations start without waiting for the response slot
   assign start_close = (mode_ff == MODE_LOADING) && (item.func == FUNC_LOAD) &&
                        (ch_opc == OPC_CLOSE) && !lc_full && !stack_empty;
   assign start_exec  = (mode_ff == MODE_READY) && (item.func == FUNC_EXEC);

   // Next state, memory controls and response
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      err_in       = err_ff;
      depth_in     = depth_ff;
      lc_in        = lc_ff;
      pc_in        = pc_ff;
      dp_in        = dp_ff;
      mate_in      = mate_ff;
      byte_in      = byte_ff;
      eof_in       = eof_ff;
      instr_we     = 1'b0;
      instr_re     = 1'b0;
      instr_waddr  = lc_ff;
      instr_wdata  = '0;
      stack_we     = 1'b0;
      stack_re     = 1'b0;
      stack_waddr  = depth_ff[SA-1:0];
      stack_raddr  = depth_dec[SA-1:0];
      cell_cmd     = '0;
      cell_wr_data = cell_rd_data;
      item_take    = 1'b0;
      res_valid    = 1'b0;
      not_loaded   = 1'b0;
      put_valid    = 1'b0;
      put_byte     = '0;
      get_taken    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (item_valid && !cell_busy) begin
               if (start_close) begin
                  // Pop the partner open; the close entry and the open patch follow
                  item_take = 1'b1;
                  stack_re  = 1'b1;
                  depth_in  = depth_dec;
                  state_in  = ST_CLOSE;
               end else if (start_exec) begin
                  // Fetch instruction and current cell
                  item_take    = 1'b1;
                  instr_re     = 1'b1;
                  cell_cmd.rd_en = 1'b1;
                  byte_in      = item.in_byte;
                  eof_in       = item.in_eof;
                  state_in     = ST_EXEC;
               end else if (out_free) begin
                  item_take = 1'b1;
                  res_valid = 1'b1;
                  case (item.func)
                     FUNC_LOAD: begin
                        if (mode_ff == MODE_LOADING && is_cmd) begin
                           if (lc_full) begin
                              err_in  = ERR_TOO_LARGE;
                              mode_in = MODE_ERROR;
                           end else if (ch_opc == OPC_OPEN) begin
                              if (stack_full) begin
                                 err_in  = ERR_DEEP;
                                 mode_in = MODE_ERROR;
                              end else begin
                                 stack_we    = 1'b1;
                                 instr_we    = 1'b1;
                                 instr_wdata = {OPC_OPEN, {PA{1'b0}}};
                                 depth_in    = depth_ff + 1'b1;
                                 lc_in       = lc_ff + 1'b1;
                              end
                           end else if (ch_opc == OPC_CLOSE) begin
                              // Only reached with an empty stack
                              err_in  = ERR_UNMATCHED;
                              mode_in = MODE_ERROR;
                           end else begin
                              instr_we    = 1'b1;
                              instr_wdata = {ch_opc, {PA{1'b0}}};
                              lc_in       = lc_ff + 1'b1;
                           end
                        end
                     end
                     FUNC_EOS: begin
                        if (mode_ff == MODE_LOADING) begin
                           if (!stack_empty) begin
                              err_in  = ERR_UNCLOSED;
                              mode_in = MODE_ERROR;
                           end else begin
                              instr_we    = 1'b1;
                              instr_wdata = {OPC_END, {PA{1'b0}}};
                              pc_in       = '0;
                              dp_in       = '0;
                              mode_in     = MODE_READY;
                           end
                        end
                     end
                     FUNC_RESTART: begin
                        if (mode_ff == MODE_READY || mode_ff == MODE_HALTED) begin
                           pc_in          = '0;
                           dp_in          = '0;
                           mode_in        = MODE_READY;
                           cell_cmd.clear = 1'b1;
                        end else if (mode_ff == MODE_LOADING) begin
                           not_loaded = 1'b1;
                        end
                     end
                     FUNC_EXEC: begin
                        // Halted and error modes leave everything as is
                        if (mode_ff == MODE_LOADING) begin
                           not_loaded = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         ST_CLOSE: begin
            // Close entry points back at its open
            instr_we    = 1'b1;
            instr_waddr = lc_ff;
            instr_wdata = {OPC_CLOSE, stack_rd_ff};
            mate_in     = stack_rd_ff;
            state_in    = ST_PATCH;
         end

         ST_PATCH: begin
            // Open entry gets the close address
            if (out_free) begin
               instr_we    = 1'b1;
               instr_waddr = mate_ff;
               instr_wdata = {OPC_OPEN, lc_ff};
               lc_in       = lc_ff + 1'b1;
               res_valid   = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
               pc_in     = pc_inc(pc_ff);
               case (ex_opc)
                  OPC_RIGHT: dp_in = (dp_ff == DA'(DATA_DEPTH - 1)) ? '0 : dp_ff + 1'b1;
                  OPC_LEFT:  dp_in = (dp_ff == '0) ? DA'(DATA_DEPTH - 1) : dp_ff - 1'b1;
                  OPC_INC: begin
                     cell_cmd.wr_en = 1'b1;
                     cell_wr_data   = cell_rd_data + 1'b1;
                  end
                  OPC_DEC: begin
                     cell_cmd.wr_en = 1'b1;
                     cell_wr_data   = cell_rd_data - 1'b1;
                  end
                  OPC_PUT: begin
                     put_valid = 1'b1;
                     put_byte  = cell_rd_data[7:0];
                  end
                  OPC_GET: begin
                     get_taken      = 1'b1;
                     cell_cmd.wr_en = 1'b1;
                     cell_wr_data   = eof_ff ? '1 : CELL_WIDTH'(byte_ff);
                  end
                  OPC_OPEN: begin
                     if (cell_zero) begin
                        pc_in = pc_inc(ex_partner);
                     end
                  end
                  OPC_CLOSE: begin
                     if (!cell_zero) begin
                        pc_in = pc_inc(ex_partner);
                     end
                  end
                  default: begin
                     // End instruction: stay put and halt
                     mode_in = MODE_HALTED;
                     pc_in   = pc_ff;
                  end
               endcase
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // Response reflects the state after this word
      res.out_valid    = put_valid;
      res.out_byte     = put_byte;
      res.input_taken  = get_taken;
      res.halted       = (mode_in == MODE_HALTED);
      res.ready_to_run = (mode_in == MODE_READY) || (mode_in == MODE_HALTED);
      res.error_code   = not_loaded ? ERR_NOT_LOADED : err_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_LOADING;
         err_ff   <= ERR_NONE;
         depth_ff <= '0;
         lc_ff    <= '0;
         pc_ff    <= '0;
         dp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         err_ff   <= err_in;
         depth_ff <= depth_in;
         lc_ff    <= lc_in;
         pc_ff    <= pc_in;
         dp_ff    <= dp_in;
      end
   end

   // Operand holding registers
   always_ff @(posedge clock) begin
      mate_ff <= mate_in;
      byte_ff <= byte_in;
      eof_ff  <= eof_in;
   end

   // Program memory
   always_ff @(posedge clock) begin
      if (instr_we) begin
         instr_mem[instr_waddr] <= instr_wdata;
      end
      if (instr_re) begin
         instr_rd_ff <= instr_mem[pc_ff];
      end
   end

   // Bracket stack
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= lc_ff;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[stack_raddr];
      end
   end

   // Checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= SDW'(STACK_DEPTH))
      else $error("bracket depth beyond stack size");

   a_loaded_balanced: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_READY || mode_ff == MODE_HALTED) |-> depth_ff == '0)
      else $error("program loaded with open brackets on the stack");

   a_res_slot: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("response issued while output register is full");

   a_no_take_in_sweep: assert property (@(posedge clock) disable iff (reset)
      item_take |-> !cell_busy)
      else $error("word taken during cell clearing sweep");

   a_exec_follows_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start_exec && item_take) |=> state_ff == ST_EXEC)
      else $error("instruction fetch not followed by execute");

endmodule

>>> test/brainfuck_machine_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for brainfuck_machine: loads one bracket-balanced program,
// then runs it word by word against a shadow copy of the machine. Depends on bfm_pkg.
module brainfuck_machine_tb;
   import bfm_pkg::*;

   localparam int PROG_DEPTH  = 4096;
   localparam int STACK_DEPTH = 512;
   localparam int DATA_DEPTH  = 128;
   localparam int WATCH_LIMIT = 2000;
   localparam int WORD_TARGET = 550;
   localparam int HOLD_CYCLES = 300;

   // Shadow of the machine: tracks program, tape and mode, queues the due status words
   class bf_shadow;
      opc_type      prog_op   [PROG_DEPTH];
      logic [11:0]  prog_mate [PROG_DEPTH];
      logic [11:0]  open_stack [STACK_DEPTH];
      logic [31:0]  tape [DATA_DEPTH];
      int           open_depth;
      int           prog_len;
      logic [11:0]  pc;
      logic [6:0]   dp;
      mode_type     mode;
      err_type      fault;
      result_type   status_due[$];
      int           mismatches;

      function new();
         foreach (prog_op[i]) begin
            prog_op[i] = OPC_END;
            prog_mate[i] = '0;
         end
         foreach (tape[i]) tape[i] = '0;
         open_depth = 0;
         prog_len = 0;
         pc = '0;
         dp = '0;
         mode = MODE_LOADING;
         fault = ERR_NONE;
         mismatches = 0;
      endfunction

      function void latch_fault(err_type code);
         fault = code;
         mode = MODE_ERROR;
      endfunction

      // One accepted request word: update the shadow, queue the status word it causes
      function void apply_request(func_type f, logic [7:0] ch, logic [7:0] ib, logic eof);
         result_type  st;
         opc_type     op;
         bit          is_cmd;
         bit          too_early;
         logic [31:0] cur_val;
         logic [11:0] next_pc;
         st = '0;
         too_early = 0;
         case (f)
            FUNC_LOAD: begin
               if (mode == MODE_LOADING) begin
                  is_cmd = 1;
                  op = OPC_END;
                  case (ch)
                     CH_RIGHT: op = OPC_RIGHT;
                     CH_LEFT:  op = OPC_LEFT;
                     CH_INC:   op = OPC_INC;
                     CH_DEC:   op = OPC_DEC;
                     CH_PUT:   op = OPC_PUT;
                     CH_GET:   op = OPC_GET;
                     CH_OPEN:  op = OPC_OPEN;
                     CH_CLOSE: op = OPC_CLOSE;
                     default:  is_cmd = 0;
                  endcase
                  if (is_cmd) begin
                     if (prog_len + 1 >= PROG_DEPTH) begin
                        latch_fault(ERR_TOO_LARGE);
                     end else if (op == OPC_OPEN && open_depth >= STACK_DEPTH) begin
                        latch_fault(ERR_DEEP);
                     end else if (op == OPC_CLOSE && open_depth == 0) begin
                        latch_fault(ERR_UNMATCHED);
                     end else begin
                        prog_op[prog_len] = op;
                        prog_mate[prog_len] = '0;
                        if (op == OPC_OPEN) begin
                           open_stack[open_depth] = 12'(prog_len);
                           open_depth++;
                        end else if (op == OPC_CLOSE) begin
                           open_depth--;
                           prog_mate[prog_len] = open_stack[open_depth];
                           prog_mate[open_stack[open_depth]] = 12'(prog_len);
                        end
                        prog_len++;
                     end
                  end
               end
            end
            FUNC_EOS: begin
               if (mode == MODE_LOADING) begin
                  if (open_depth != 0) begin
                     latch_fault(ERR_UNCLOSED);
                  end else if (prog_len < PROG_DEPTH) begin
                     prog_op[prog_len] = OPC_END;
                     prog_mate[prog_len] = '0;
                     pc = '0;
                     dp = '0;
                     mode = MODE_READY;
                  end else begin
                     latch_fault(ERR_TOO_LARGE);
                  end
               end
            end
            FUNC_RESTART: begin
               if (mode == MODE_READY || mode == MODE_HALTED) begin
                  pc = '0;
                  dp = '0;
                  foreach (tape[i]) tape[i] = '0;
                  mode = MODE_READY;
               end else if (mode == MODE_LOADING) begin
                  too_early = 1;
               end
            end
            default: begin
               if (mode == MODE_LOADING) begin
                  too_early = 1;
               end else if (mode == MODE_READY) begin
                  op = prog_op[pc];
                  cur_val = tape[dp];
                  next_pc = pc + 12'd1;
                  case (op)
                     OPC_RIGHT: dp = dp + 7'd1;
                     OPC_LEFT:  dp = dp - 7'd1;
                     OPC_INC:   tape[dp] = cur_val + 32'd1;
                     OPC_DEC:   tape[dp] = cur_val - 32'd1;
                     OPC_PUT: begin
                        st.out_valid = 1'b1;
                        st.out_byte = cur_val[7:0];
                     end
                     OPC_GET: begin
                        st.input_taken = 1'b1;
                        tape[dp] = eof ? '1 : {24'd0, ib};
                     end
                     OPC_OPEN:  if (cur_val == 0) next_pc = prog_mate[pc] + 12'd1;
                     OPC_CLOSE: if (cur_val != 0) next_pc = prog_mate[pc] + 12'd1;
                     default: begin
                        mode = MODE_HALTED;
                        next_pc = pc;
                     end
                  endcase
                  pc = next_pc;
               end
            end
         endcase
         st.halted = (mode == MODE_HALTED);
         st.ready_to_run = (mode == MODE_READY || mode == MODE_HALTED);
         st.error_code = too_early ? ERR_NOT_LOADED : fault;
         status_due.push_back(st);
      endfunction

      function void compare_field(string label, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatches++;
         end
      endfunction

      // One accepted response word against the oldest due status word
      function void check_status(logic [15:0] word);
         result_type st;
         if (status_due.size() == 0) begin
            $display("%0t: response word %h with nothing expected, expected none, actual %h",
                     $time, word, word);
            mismatches++;
            return;
         end
         st = status_due.pop_front();
         compare_field("out_valid",    st.out_valid,    word[0]);
         compare_field("out_byte",     st.out_byte,     word[8:1]);
         compare_field("input_taken",  st.input_taken,  word[9]);
         compare_field("halted",       st.halted,       word[10]);
         compare_field("ready_to_run", st.ready_to_run, word[11]);
         compare_field("error_code",   st.error_code,   word[14:12]);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // src_char[7:0], in_byte[15:8], in_eof[16], zero pad
   logic [1:0]  req_tuser = '0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // out_valid[0], out_byte[8:1], input_taken[9],
                                  // halted[10], ready_to_run[11], error_code[14:12]

   bf_shadow shadow;
   int       words_sent = 0;
   int       words_seen = 0;
   int       calm_tx = 0;
   int       calm_rx = 0;

   // Opening program: eof input, wrap of the pointer, loop exit, skipped loop
   logic [7:0] opener [16] = '{CH_GET, CH_PUT, CH_DEC, CH_PUT, CH_LEFT, CH_RIGHT, CH_INC,
                               CH_PUT, CH_GET, CH_OPEN, CH_GET, CH_CLOSE, CH_OPEN, CH_PUT,
                               CH_CLOSE, CH_PUT};
   logic [7:0] plain_ops [6] = '{CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_PUT, CH_GET};

   brainfuck_machine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Mostly no gap, some short ones, a few long; now and then a calm stretch
   function automatic int pick_gap(inout int calm);
      int r;
      r = $urandom_range(0, 29);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if (r == 0) begin
         calm = $urandom_range(10, 30);
         return 0;
      end
      if (r < 18) return 0;
      if (r < 27) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one request word after a random gap and wait for its acceptance
   task automatic push_word(func_type f, logic [7:0] ch, logic [7:0] ib, logic eof);
      repeat (pick_gap(calm_tx)) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, eof, ib, ch};
      req_tuser <= f;
      do @(posedge clock); while (!req_tready);
      shadow.apply_request(f, ch, ib, eof);
      words_sent++;
   endtask

   // Response side: random stalls, one long hold-off early on
   initial begin
      bit held;
      held = 0;
      while (reset) @(negedge clock);
      forever begin
         if (!held && words_seen >= 60) begin
            held = 1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         repeat (pick_gap(calm_rx)) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         shadow.check_status(rsp_tdata);
         words_seen++;
      end
   end

   // Watchdog on cycles without any accepted word
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCH_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no word accepted for %0d cycles", $time, WATCH_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [7:0] ch;
      logic [7:0] ib;
      logic       eof;
      func_type   f;
      int         depth;
      int         r;
      shadow = new();
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Execute and restart before any program
      push_word(FUNC_EXEC, 8'h00, 8'h00, 1'b0);
      push_word(FUNC_RESTART, 8'hFF, 8'hFF, 1'b1);

      // Bytes that are not commands are dropped
      push_word(FUNC_LOAD, 8'h00, 8'hFF, 1'b1);
      push_word(FUNC_LOAD, 8'hFF, 8'h00, 1'b0);
      push_word(FUNC_LOAD, 8'h61, 8'h5A, 1'b0);

      foreach (opener[k])
         push_word(FUNC_LOAD, opener[k], 8'($urandom), 1'($urandom));

      // Random balanced body; every loop reads input just before its close
      depth = 0;
      for (int k = 0; k < 60; k++) begin
         r = $urandom_range(0, 15);
         if (r == 0 && depth < 4) begin
            ch = CH_OPEN;
            depth++;
         end else if (r == 1 && depth > 0) begin
            push_word(FUNC_LOAD, CH_GET, 8'($urandom), 1'($urandom));
            ch = CH_CLOSE;
            depth--;
         end else if (r <= 3) begin
            do ch = 8'($urandom);
            while (ch inside {CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_PUT, CH_GET,
                              CH_OPEN, CH_CLOSE});
         end else begin
            ch = plain_ops[$urandom_range(0, 5)];
         end
         push_word(FUNC_LOAD, ch, 8'($urandom), 1'($urandom));
      end
      while (depth > 0) begin
         push_word(FUNC_LOAD, CH_GET, 8'($urandom), 1'($urandom));
         push_word(FUNC_LOAD, CH_CLOSE, 8'($urandom), 1'($urandom));
         depth--;
      end
      push_word(FUNC_EOS, 8'($urandom), 8'($urandom), 1'($urandom));

      // Step through the opening program: eof on the first input, bit 7 and zero later
      for (int k = 0; k < 16; k++)
         push_word(FUNC_EXEC, 8'($urandom), (k == 8) ? 8'h80 : 8'h00, k == 0);

      // Loading words are ignored once a program is in place
      push_word(FUNC_LOAD, CH_CLOSE, 8'($urandom), 1'($urandom));
      push_word(FUNC_EOS, 8'($urandom), 8'($urandom), 1'($urandom));
      push_word(FUNC_RESTART, 8'($urandom), 8'($urandom), 1'($urandom));

      // Random run: mostly single steps, restart soon after a halt
      while (words_sent < WORD_TARGET) begin
         r = $urandom_range(0, 199);
         ib = ($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom);
         eof = ($urandom_range(0, 3) == 0);
         if (shadow.mode == MODE_HALTED)
            f = (r < 60) ? FUNC_RESTART : FUNC_EXEC;
         else if (r < 1)
            f = FUNC_RESTART;
         else if (r < 4)
            f = FUNC_LOAD;
         else if (r < 5)
            f = FUNC_EOS;
         else
            f = FUNC_EXEC;
         push_word(f, 8'($urandom), ib, eof);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (shadow.status_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.status_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
